// ===== hdl/fpp3d_pkg.sv =====
package fpp3d_pkg;

  // store size and derived widths
  localparam int MAX_POINTS = 32;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int COUNT_W    = $clog2(MAX_POINTS + 1);

  // fixed field widths
  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int DIST_W     = 36;
  localparam int OUT_IDX_W  = 5;
  localparam int POINT_W    = 3 * COORD_W;

  // one stored point
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

endpackage

// ===== hdl/fpp3d_ram.sv =====
module fpp3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fpp3d_dist_unit.sv =====
module fpp3d_dist_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  fpp3d_pkg::point_t                    point_a,
  input  fpp3d_pkg::point_t                    point_b,
  output logic                                 done,
  output logic [fpp3d_pkg::DIST_W-1:0]         pair_dist
);

  logic signed [fpp3d_pkg::DIFF_W-1:0] dx;
  logic signed [fpp3d_pkg::DIFF_W-1:0] dy;
  logic signed [fpp3d_pkg::DIFF_W-1:0] dz;
  logic signed [fpp3d_pkg::DIFF_W-1:0] mul_in;
  logic signed [fpp3d_pkg::SQ_W-1:0]   prod;
  logic [fpp3d_pkg::DIST_W-1:0]        acc;
  logic [fpp3d_pkg::DIST_W-1:0]        prod_ext;
  logic [2:0]                          step;

  // pick the axis fed to the shared squaring multiplier
  always_comb begin
    unique case (step)
      3'd1:    mul_in = dx;
      3'd2:    mul_in = dy;
      default: mul_in = dz;
    endcase
  end

  assign prod_ext = fpp3d_pkg::DIST_W'($unsigned(prod));

  // step sequencer and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= 3'd1;
      end else if (step == 3'd4) begin
        step <= 3'd0;
        done <= 1'b1;
      end else if (step != 3'd0) begin
        step <= step + 3'd1;
      end
    end
  end

  // differences, one square per cycle, then accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      dx <= {point_a.x[fpp3d_pkg::COORD_W-1], point_a.x}
            - {point_b.x[fpp3d_pkg::COORD_W-1], point_b.x};
      dy <= {point_a.y[fpp3d_pkg::COORD_W-1], point_a.y}
            - {point_b.y[fpp3d_pkg::COORD_W-1], point_b.y};
      dz <= {point_a.z[fpp3d_pkg::COORD_W-1], point_a.z}
            - {point_b.z[fpp3d_pkg::COORD_W-1], point_b.z};
    end
    if (step >= 3'd1 && step <= 3'd3) begin
      prod <= mul_in * mul_in;
    end
    if (step == 3'd2) begin
      acc <= prod_ext;
    end else if (step == 3'd3 || step == 3'd4) begin
      acc <= acc + prod_ext;
    end
  end

  assign pair_dist = acc;

endmodule

// ===== hdl/farthest_point_pair_3d_core.sv =====
// Farthest pair search over a set of up to 32 points in 3D. Points are taken
// one per cycle with in_stall low and stored in order; points beyond the
// store size are dropped and reported through overflow. The point marked
// last_point starts a search over all n(n-1)/2 pairs, during which in_stall
// stays high. For each pair the two point memories are read through their
// registered read ports, then the distance unit squares the three axis
// differences one after the other on a single 17x17 multiplier and sums
// them. Sets of fewer than two points skip the search. The result is
// the first strictly greatest pair in scan order (outer index j, inner i<j)
// and waits in an output register until taken; the next set may load
// meanwhile.
module farthest_point_pair_3d_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [fpp3d_pkg::COORD_W-1:0]   coord_x,
  input  logic signed [fpp3d_pkg::COORD_W-1:0]   coord_y,
  input  logic signed [fpp3d_pkg::COORD_W-1:0]   coord_z,
  input  logic                                   last_point,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [fpp3d_pkg::OUT_IDX_W-1:0]        first_index,
  output logic [fpp3d_pkg::OUT_IDX_W-1:0]        second_index,
  output logic [fpp3d_pkg::DIST_W-1:0]           squared_distance,
  output logic                                   overflow
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                          state;
  logic [fpp3d_pkg::COUNT_W-1:0]       count;
  logic [fpp3d_pkg::COUNT_W-1:0]       count_next;
  logic                                dropped;
  logic                                dropped_next;
  logic [fpp3d_pkg::IDX_W-1:0]         idx_i;
  logic [fpp3d_pkg::IDX_W-1:0]         idx_j;
  logic [fpp3d_pkg::IDX_W-1:0]         best_i;
  logic [fpp3d_pkg::IDX_W-1:0]         best_j;
  logic [fpp3d_pkg::DIST_W-1:0]        best;
  logic                                in_take;
  logic                                out_take;
  logic                                store_free;
  logic                                dist_start;
  logic                                dist_done;
  logic [fpp3d_pkg::DIST_W-1:0]        pair_dist;
  fpp3d_pkg::point_t                   wr_point;
  fpp3d_pkg::point_t                   point_i;
  fpp3d_pkg::point_t                   point_j;
  logic [fpp3d_pkg::IDX_W+fpp3d_pkg::OUT_IDX_W-1:0] best_i_ext;
  logic [fpp3d_pkg::IDX_W+fpp3d_pkg::OUT_IDX_W-1:0] best_j_ext;

  assign in_stall   = (state != S_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign out_take   = out_valid && !out_stall;
  assign store_free = (count < fpp3d_pkg::COUNT_W'(fpp3d_pkg::MAX_POINTS));
  assign dist_start = (state == S_START);

  assign wr_point.x = coord_x;
  assign wr_point.y = coord_y;
  assign wr_point.z = coord_z;

  // fill level and drop flag after this transaction
  always_comb begin
    count_next   = count;
    dropped_next = dropped;
    if (store_free) begin
      count_next = count + fpp3d_pkg::COUNT_W'(1);
    end else begin
      dropped_next = 1'b1;
    end
  end

  // two copies of the point store, one read at i and one at j
  fpp3d_ram #(
    .WIDTH(fpp3d_pkg::POINT_W),
    .DEPTH(fpp3d_pkg::MAX_POINTS)
  ) u_store_i (
    .clk   (clk),
    .we    (in_take && store_free),
    .waddr (count[fpp3d_pkg::IDX_W-1:0]),
    .wdata (wr_point),
    .raddr (idx_i),
    .rdata (point_i)
  );

  fpp3d_ram #(
    .WIDTH(fpp3d_pkg::POINT_W),
    .DEPTH(fpp3d_pkg::MAX_POINTS)
  ) u_store_j (
    .clk   (clk),
    .we    (in_take && store_free),
    .waddr (count[fpp3d_pkg::IDX_W-1:0]),
    .wdata (wr_point),
    .raddr (idx_j),
    .rdata (point_j)
  );

  fpp3d_dist_unit u_dist (
    .clk       (clk),
    .rst       (rst),
    .start     (dist_start),
    .point_a   (point_i),
    .point_b   (point_j),
    .done      (dist_done),
    .pair_dist (pair_dist)
  );

  // sequencer over the pair loops
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_take && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            count   <= count_next;
            dropped <= dropped_next;
            if (last_point) begin
              best   <= '0;
              best_i <= '0;
              best_j <= '0;
              idx_i  <= '0;
              idx_j  <= fpp3d_pkg::IDX_W'(1);
              if (count_next < fpp3d_pkg::COUNT_W'(2)) begin
                state <= S_DONE;
              end else begin
                state <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (dist_done) begin
            if (pair_dist > best) begin
              best   <= pair_dist;
              best_i <= idx_i;
              best_j <= idx_j;
            end
            priority if (fpp3d_pkg::COUNT_W'(idx_i) + fpp3d_pkg::COUNT_W'(1)
                         < fpp3d_pkg::COUNT_W'(idx_j)) begin
              idx_i <= idx_i + fpp3d_pkg::IDX_W'(1);
              state <= S_READ;
            end else if (fpp3d_pkg::COUNT_W'(idx_j) + fpp3d_pkg::COUNT_W'(1)
                         < count) begin
              idx_i <= '0;
              idx_j <= idx_j + fpp3d_pkg::IDX_W'(1);
              state <= S_READ;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            count     <= '0;
            dropped   <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign best_i_ext = {{fpp3d_pkg::OUT_IDX_W{1'b0}}, best_i};
  assign best_j_ext = {{fpp3d_pkg::OUT_IDX_W{1'b0}}, best_j};

  // result register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      first_index      <= best_i_ext[fpp3d_pkg::OUT_IDX_W-1:0];
      second_index     <= best_j_ext[fpp3d_pkg::OUT_IDX_W-1:0];
      squared_distance <= best;
      overflow         <= dropped;
    end
  end

endmodule

// ===== hdl/fpp3d_checker.sv =====
module fpp3d_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  last_point,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [fpp3d_pkg::OUT_IDX_W-1:0]       first_index,
  input logic [fpp3d_pkg::OUT_IDX_W-1:0]       second_index,
  input logic [fpp3d_pkg::DIST_W-1:0]          squared_distance,
  input logic                                  overflow
);

  // a waiting result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // a waiting result does not change
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(squared_distance) && $stable(first_index)
      && $stable(second_index) && $stable(overflow))
    else $error("result changed while stalled");

  // nothing is offered straight out of reset
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered right after reset");

  // a zero distance keeps the initial pair
  assert property (@(posedge clk) disable iff (rst)
    out_valid && squared_distance == '0 |-> first_index == '0 && second_index == '0)
    else $error("zero distance with a nonzero pair");

  // with no result waiting, none appears in the cycle after the last point is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_point && !out_valid |=> !out_valid)
    else $error("result offered in the cycle after the last point");

endmodule

bind farthest_point_pair_3d_core fpp3d_checker u_checker (.*);

// ===== tb/farthest_point_pair_3d_core_tb.sv =====
module farthest_point_pair_3d_core_tb;
  import fpp3d_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int ITEM_TARGET = 1300;
  localparam int IDLE_PCT    = 21;
  localparam int REPORT_CAP  = 50;

  // how the coordinates of one random set are spread
  typedef enum int {
    SPREAD_FULL,
    SPREAD_GRID,
    SPREAD_CORNERS,
    SPREAD_SAME,
    SPREAD_LOCAL
  } spread_t;

  typedef struct {
    logic [OUT_IDX_W-1:0] first_idx;
    logic [OUT_IDX_W-1:0] second_idx;
    logic [DIST_W-1:0]    sq_dist;
    logic                 dropped;
  } pair_result_t;

  typedef struct {
    point_t       pt;
    logic         last;
    bit           typed;
    pair_result_t want;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic signed [COORD_W-1:0] coord_z = '0;
  logic                      last_point = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [OUT_IDX_W-1:0]      first_index;
  logic [OUT_IDX_W-1:0]      second_index;
  logic [DIST_W-1:0]         squared_distance;
  logic                      overflow;

  // predicted store contents of the set being loaded
  point_t      set_points [MAX_POINTS];
  int unsigned set_size;
  bit          set_dropped;

  pair_result_t expected_pairs [$];
  stim_row_t    directed_rows [$];

  int error_count;
  int results_seen;
  int sets_sent;
  int points_sent;
  int overflow_sets;
  int largest_set;
  int quiet_cycles;
  bit steady_run;

  farthest_point_pair_3d_core dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .coord_x          (coord_x),
    .coord_y          (coord_y),
    .coord_z          (coord_z),
    .last_point       (last_point),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .first_index      (first_index),
    .second_index     (second_index),
    .squared_distance (squared_distance),
    .overflow         (overflow)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    error_count++;
    if (error_count <= REPORT_CAP)
      $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
  endtask

  // exact squared euclidean distance, differences kept at 17 bits
  function automatic logic [DIST_W-1:0] pair_distance(point_t a, point_t b);
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    dx = $signed(a.x) - $signed(b.x);
    dy = $signed(a.y) - $signed(b.y);
    dz = $signed(a.z) - $signed(b.z);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // store the point, and on the last one scan all pairs with j outer, i < j
  function automatic bit predict_farthest_pair(point_t p, logic last_pt,
                                               output pair_result_t r);
    logic [DIST_W-1:0] best;
    logic [DIST_W-1:0] d;
    r    = '{default: '0};
    best = '0;
    if (set_size < MAX_POINTS) begin
      set_points[set_size] = p;
      set_size++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last_pt)
      return 1'b0;
    for (int j = 0; j < set_size; j++) begin
      for (int i = 0; i < j; i++) begin
        d = pair_distance(set_points[i], set_points[j]);
        // strictly greater only, so the first of equal pairs stays
        if (d > best) begin
          best         = d;
          r.first_idx  = OUT_IDX_W'(i);
          r.second_idx = OUT_IDX_W'(j);
        end
      end
    end
    r.sq_dist   = best;
    r.dropped   = set_dropped;
    set_size    = 0;
    set_dropped = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord(spread_t s,
                                                           logic signed [COORD_W-1:0] centre);
    case (s)
      SPREAD_GRID: begin
        return COORD_W'(256 * $urandom_range(0, 2)) - COORD_W'(256);
      end
      SPREAD_CORNERS: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      SPREAD_SAME: begin
        return centre;
      end
      SPREAD_LOCAL: begin
        return centre + COORD_W'($urandom_range(0, 32)) - COORD_W'(16);
      end
      default: begin
        return COORD_W'($urandom());
      end
    endcase
  endfunction

  // one input transaction, with random idle cycles ahead of it
  task automatic send_point(point_t p, logic last_pt, bit typed, pair_result_t want);
    pair_result_t predicted;
    while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    coord_x    <= p.x;
    coord_y    <= p.y;
    coord_z    <= p.z;
    last_point <= last_pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    points_sent++;
    if (last_pt)
      sets_sent++;
    if (predict_farthest_pair(p, last_pt, predicted))
      expected_pairs.push_back(typed ? want : predicted);
  endtask

  task automatic send_set(int n, spread_t s);
    point_t       centre;
    point_t       p;
    pair_result_t unused = '{default: '0};
    centre.x = COORD_W'($urandom());
    centre.y = COORD_W'($urandom());
    centre.z = COORD_W'($urandom());
    for (int k = 0; k < n; k++) begin
      p.x = pick_coord(s, centre.x);
      p.y = pick_coord(s, centre.y);
      p.z = pick_coord(s, centre.z);
      send_point(p, k == n - 1, 1'b0, unused);
    end
    if (n > MAX_POINTS)
      overflow_sets++;
    if (n > largest_set)
      largest_set = n;
  endtask

  task automatic add_row(int x, int y, int z, logic last_pt, bit typed,
                         int fi, int si, logic [DIST_W-1:0] d);
    stim_row_t row;
    row.pt.x            = COORD_W'(x);
    row.pt.y            = COORD_W'(y);
    row.pt.z            = COORD_W'(z);
    row.last            = last_pt;
    row.typed           = typed;
    row.want.first_idx  = OUT_IDX_W'(fi);
    row.want.second_idx = OUT_IDX_W'(si);
    row.want.sq_dist    = d;
    row.want.dropped    = 1'b0;
    directed_rows.push_back(row);
  endtask

  // result side: compare each taken transaction, then pick the next stall
  always @(posedge clk) begin
    pair_result_t head;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_pairs.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        head = expected_pairs.pop_front();
        if (first_index !== head.first_idx)
          report_mismatch("first_index", first_index, head.first_idx);
        if (second_index !== head.second_idx)
          report_mismatch("second_index", second_index, head.second_idx);
        if (squared_distance !== head.sq_dist)
          report_mismatch("squared_distance", squared_distance, head.sq_dist);
        if (overflow !== head.dropped)
          report_mismatch("overflow", overflow, head.dropped);
      end
    end
    out_stall <= !steady_run && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // cycles since the last transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int      size_pick;
    int      spread_pick;
    int      n;
    spread_t s;

    // lone point: nothing to pair with
    add_row(0, 0, 0, 1'b1, 1'b1, 0, 0, '0);
    // opposite corners of the coordinate cube give the largest distance
    add_row(-32768, -32768, -32768, 1'b0, 1'b0, 0, 0, '0);
    add_row(32767, 32767, 32767, 1'b1, 1'b1, 0, 1, 36'd12884508675);
    // repeated point: no pair beats zero
    add_row(100, -5, 7, 1'b0, 1'b0, 0, 0, '0);
    add_row(100, -5, 7, 1'b1, 1'b1, 0, 0, '0);
    // square of side 256: both diagonals tie, the first in scan order is kept
    add_row(0, 0, 0, 1'b0, 1'b0, 0, 0, '0);
    add_row(256, 0, 0, 1'b0, 1'b0, 0, 0, '0);
    add_row(0, 256, 0, 1'b0, 1'b0, 0, 0, '0);
    add_row(256, 256, 0, 1'b1, 1'b1, 1, 2, 36'd131072);
    // single axis extremes with mixed signs
    add_row(32767, 0, 0, 1'b0, 1'b0, 0, 0, '0);
    add_row(-32768, 0, 0, 1'b0, 1'b0, 0, 0, '0);
    add_row(0, -32768, 32767, 1'b1, 1'b0, 0, 0, '0);
    // smallest steps around zero
    add_row(-1, 1, -1, 1'b0, 1'b0, 0, 0, '0);
    add_row(0, 0, 0, 1'b0, 1'b0, 0, 0, '0);
    add_row(1, -1, 1, 1'b1, 1'b0, 0, 0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      send_point(directed_rows[r].pt, directed_rows[r].last, directed_rows[r].typed,
                 directed_rows[r].want);

    // random sets, mostly small, a few full and a few past capacity
    while (points_sent < ITEM_TARGET) begin
      steady_run = (sets_sent >= 60 && sets_sent < 90);
      if (sets_sent % 25 == 12) begin
        // hold the sender until every pending result is out
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_pairs.size() != 0);
      end
      size_pick   = $urandom_range(0, 99);
      spread_pick = $urandom_range(0, 99);
      if (size_pick < 8)
        n = $urandom_range(1, 2);
      else if (size_pick < 70)
        n = $urandom_range(3, 8);
      else if (size_pick < 92)
        n = $urandom_range(9, 20);
      else if (size_pick < 96)
        n = MAX_POINTS;
      else
        n = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 4);
      if (spread_pick < 45)
        s = SPREAD_FULL;
      else if (spread_pick < 60)
        s = SPREAD_GRID;
      else if (spread_pick < 72)
        s = SPREAD_CORNERS;
      else if (spread_pick < 82)
        s = SPREAD_SAME;
      else
        s = SPREAD_LOCAL;
      send_set(n, s);
    end
    steady_run = 1'b0;

    // drain, then allow time for any stray result
    in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d points in %0d sets, %0d sets past capacity, largest set %0d",
             points_sent, sets_sent, overflow_sets, largest_set);
    $display("%0d farthest pair results compared, %0d mismatches", results_seen, error_count);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
